/* hdl/hsv_to_rgb_converter_top_assert.svh */
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HSV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HSV_ASSERT_NOW(label, ante, cons, msg)
`define HSV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/hsv_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, sector codes and the inter-stage control struct.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int HUE_FULL   = 360;
	localparam int SECTOR_DEG = 60;
	localparam int CHAN_MAX   = 255;

	// hue + 92*360 is always positive in 17 bits; reciprocal of 360 is exact there
	localparam int HUE_W           = 17;
	localparam int HUE_BIAS        = 92 * HUE_FULL;
	localparam int HUE_RECIP_SHIFT = 25;
	localparam int HUE_RECIP       = ((1 << HUE_RECIP_SHIFT) + HUE_FULL - 1) / HUE_FULL;
	localparam int QUOT_W          = 8;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic    valid;
		sector_t sector;
		logic [5:0] rem;
	} hsv_sect_t;

endpackage

/* hdl/hsv_hue.sv */
// ----------------------------------------------------------------------------
// Hue front end
// Wraps the hue into 0..359, splits it into sector and in-sector remainder,
// and clamps saturation and value to 0..1. Three register stages.
// ----------------------------------------------------------------------------
module hsv_hue import hsv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int UW = FRAC_BITS + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                hsv_valid,
	input  logic signed [15:0]  hue_degrees,
	input  logic signed [15:0]  saturation,
	input  logic signed [15:0]  brightness,
	output hsv_sect_t           sect_s3,
	output logic [UW-1:0]       sat_s3,
	output logic [UW-1:0]       val_s3
);

	localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

	function automatic logic [UW-1:0] clamp_unit(input logic signed [15:0] x);
		logic [UW-1:0] res;
		if (x[15]) begin
			res = '0;
		end else if (x > $signed(16'(ONE))) begin
			res = ONE;
		end else begin
			res = x[UW-1:0];
		end
		return res;
	endfunction

	logic [HUE_W-1:0]    u_c;
	logic [2*HUE_W-1:0]  prod_c;
	logic [HUE_W-1:0]    hue_c;
	sector_t             sector_c;
	logic [8:0]          base_c;
	logic [8:0]          rem_c;

	logic                valid_s1, valid_s2, valid_s3;
	logic [HUE_W-1:0]    u_s1;
	logic [QUOT_W-1:0]   quot_s1;
	logic [UW-1:0]       sat_s1, val_s1, sat_s2, val_s2;
	logic [8:0]          hue_s2;
	sector_t             sector_s3;
	logic [5:0]          rem_s3;

	// stage 1: bias to positive, quotient by 360 through reciprocal
	assign u_c    = {hue_degrees[15], hue_degrees} + HUE_W'(HUE_BIAS);
	assign prod_c = (2*HUE_W)'(u_c) * (2*HUE_W)'(HUE_RECIP);

	// stage 2: remainder
	assign hue_c = u_s1 - HUE_W'(quot_s1) * HUE_W'(HUE_FULL);

	// stage 3: sector split
	always_comb begin
		if (hue_s2 >= 9'(5 * SECTOR_DEG)) begin
			sector_c = SEC_MR;
		end else if (hue_s2 >= 9'(4 * SECTOR_DEG)) begin
			sector_c = SEC_BM;
		end else if (hue_s2 >= 9'(3 * SECTOR_DEG)) begin
			sector_c = SEC_CB;
		end else if (hue_s2 >= 9'(2 * SECTOR_DEG)) begin
			sector_c = SEC_GC;
		end else if (hue_s2 >= 9'(SECTOR_DEG)) begin
			sector_c = SEC_YG;
		end else begin
			sector_c = SEC_RY;
		end
		case (sector_c)
			SEC_YG:  base_c = 9'(SECTOR_DEG);
			SEC_GC:  base_c = 9'(2 * SECTOR_DEG);
			SEC_CB:  base_c = 9'(3 * SECTOR_DEG);
			SEC_BM:  base_c = 9'(4 * SECTOR_DEG);
			SEC_MR:  base_c = 9'(5 * SECTOR_DEG);
			default: base_c = '0;
		endcase
		rem_c = hue_s2 - base_c;
	end

	assign sect_s3 = '{valid: valid_s3, sector: sector_s3, rem: rem_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= hsv_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1      <= u_c;
			quot_s1   <= prod_c[HUE_RECIP_SHIFT +: QUOT_W];
			sat_s1    <= clamp_unit(saturation);
			val_s1    <= clamp_unit(brightness);
			hue_s2    <= hue_c[8:0];
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
			sector_s3 <= sector_c;
			rem_s3    <= rem_c[5:0];
			sat_s3    <= sat_s2;
			val_s3    <= val_s2;
		end
	end

endmodule

/* hdl/hsv_chan.sv */
// ----------------------------------------------------------------------------
// Channel back end
// Forms p, q, t numerators, scales by value, converts to 8-bit channels and
// routes them by sector. Three register stages, the last is the output.
// ----------------------------------------------------------------------------
module hsv_chan import hsv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int UW = FRAC_BITS + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  hsv_sect_t      sect_s3,
	input  logic [UW-1:0]  sat_s3,
	input  logic [UW-1:0]  val_s3,
	output logic           rgb_valid,
	output logic [7:0]     red,
	output logic [7:0]     green,
	output logic [7:0]     blue
);

	localparam int NW = FRAC_BITS + 6;
	localparam int MW = UW + NW;
	localparam int CW = MW + 5;
	localparam int SH = 2 * FRAC_BITS + 2;
	localparam logic [UW-1:0] ONE  = UW'(1) << FRAC_BITS;
	localparam logic [NW-1:0] FULL = NW'(SECTOR_DEG) << FRAC_BITS;

	// 255/60 = 17/4, so channel = floor(17*v*n / 2^(2F+2))
	function automatic logic [7:0] to_chan(input logic [MW-1:0] m);
		logic [CW-1:0] x;
		x = (CW'(m) << 4) + CW'(m);
		return x[SH +: 8];
	endfunction

	logic [NW-1:0] sr_c, st_c, np_c;

	logic          valid_s4, valid_s5;
	sector_t       sector_s4, sector_s5;
	logic [UW-1:0] val_s4;
	logic [NW-1:0] np_s4, nq_s4, nt_s4;
	logic [MW-1:0] mv_s5, mp_s5, mq_s5, mt_s5;
	logic [7:0]    cv_c, cp_c, cq_c, ct_c;

	assign sr_c = NW'(sat_s3) * NW'(sect_s3.rem);
	assign st_c = NW'(sat_s3) * (NW'(SECTOR_DEG) - NW'(sect_s3.rem));
	assign np_c = NW'(SECTOR_DEG) * NW'(ONE - sat_s3);

	assign cv_c = to_chan(mv_s5);
	assign cp_c = to_chan(mp_s5);
	assign cq_c = to_chan(mq_s5);
	assign ct_c = to_chan(mt_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			rgb_valid <= 1'b0;
		end else if (en) begin
			valid_s4  <= sect_s3.valid;
			valid_s5  <= valid_s4;
			rgb_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s4 <= sect_s3.sector;
			val_s4    <= val_s3;
			np_s4     <= np_c;
			nq_s4     <= FULL - sr_c;
			nt_s4     <= FULL - st_c;
			sector_s5 <= sector_s4;
			mv_s5     <= MW'(val_s4) * MW'(FULL);
			mp_s5     <= MW'(val_s4) * MW'(np_s4);
			mq_s5     <= MW'(val_s4) * MW'(nq_s4);
			mt_s5     <= MW'(val_s4) * MW'(nt_s4);
			case (sector_s5)
				SEC_YG: begin
					red <= cq_c; green <= cv_c; blue <= cp_c;
				end
				SEC_GC: begin
					red <= cp_c; green <= cv_c; blue <= ct_c;
				end
				SEC_CB: begin
					red <= cp_c; green <= cq_c; blue <= cv_c;
				end
				SEC_BM: begin
					red <= ct_c; green <= cp_c; blue <= cv_c;
				end
				SEC_MR: begin
					red <= cv_c; green <= cp_c; blue <= cq_c;
				end
				default: begin
					red <= cv_c; green <= ct_c; blue <= cp_c;
				end
			endcase
		end
	end

endmodule

/* hdl/hsv_to_rgb_converter_top.sv */
// Throughput: one transfer per cycle; six-stage pipeline with one global
// advance enable, which holds while the output register is full and stalled.
// Reset: arst_n clears all stage valid bits asynchronously; data needs none.
`include "hsv_to_rgb_converter_top_assert.svh"
// ----------------------------------------------------------------------------
// HSV to RGB converter top level
// Hue wrap and sector split, then per-channel scaling to 8-bit RGB.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top import hsv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsv_valid,
	output logic               hsv_stall,
	input  logic signed [15:0] hue_degrees,
	input  logic signed [15:0] saturation,
	input  logic signed [15:0] brightness,
	output logic               rgb_valid,
	input  logic               rgb_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	localparam int UW = FRAC_BITS + 1;

	logic          en;
	hsv_sect_t     sect_s3;
	logic [UW-1:0] sat_s3, val_s3;

	assign hsv_stall = rgb_valid & rgb_stall;
	assign en        = ~hsv_stall;

	hsv_hue #(.FRAC_BITS(FRAC_BITS)) u_hue (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.hsv_valid   (hsv_valid),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness),
		.sect_s3     (sect_s3),
		.sat_s3      (sat_s3),
		.val_s3      (val_s3)
	);

	hsv_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.sect_s3   (sect_s3),
		.sat_s3    (sat_s3),
		.val_s3    (val_s3),
		.rgb_valid (rgb_valid),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	`HSV_ASSERT_NOW(a_rem_range, sect_s3.valid, sect_s3.rem < 6'(SECTOR_DEG), "sector remainder out of range")
	`HSV_ASSERT_NEXT(a_pipe_hold, rgb_valid && rgb_stall, $stable(sect_s3.valid), "pipeline moved while stalled")
	`HSV_ASSERT_NEXT(a_out_hold, rgb_valid && rgb_stall, rgb_valid && $stable({red, green, blue}), "stalled result changed")

endmodule

/* dv/hsv_to_rgb_converter_top_tb.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner colors and then random HSV transfers with bursty input
// and a patterned output stall. Every RGB transfer is checked against a typed value or a local
// fixed-point predictor, with results compared in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top_tb import hsv_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIT        = 1 << FRAC_BITS_DEF;
	localparam int N_DIRECTED  = 25;
	localparam int N_RANDOM    = 1850;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 16;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic signed [15:0] hue;
		logic signed [15:0] sat;
		logic signed [15:0] val;
		logic               typed;
		rgb_t               rgb;
	} color_row_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               hsv_valid   = 1'b0;
	logic               hsv_stall;
	logic signed [15:0] hue_degrees = '0;
	logic signed [15:0] saturation  = '0;
	logic signed [15:0] brightness  = '0;
	logic               rgb_valid;
	logic               rgb_stall   = 1'b0;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	rgb_t rgb_expect_q[$];
	rgb_t pending_rgb;
	rgb_t popped_rgb;
	int   mismatch_count = 0;
	int   items_sent     = 0;
	int   results_seen   = 0;
	int   cycle_count    = 0;
	int   burst_left     = 0;
	bit   hold_done      = 0;

	// unit-scale corners are typed in, the rest come from the predictor
	color_row_t color_tab [N_DIRECTED] = '{
		'{16'sd0,      16'sd0,      16'sd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
		'{16'sd0,      16'sd0,      16'sd256,    1'b1, '{8'd255, 8'd255, 8'd255}},
		'{16'sd0,      16'sd256,    16'sd256,    1'b1, '{8'd255, 8'd0,   8'd0}},
		'{16'sd60,     16'sd256,    16'sd256,    1'b1, '{8'd255, 8'd255, 8'd0}},
		'{16'sd120,    16'sd256,    16'sd256,    1'b1, '{8'd0,   8'd255, 8'd0}},
		'{16'sd180,    16'sd256,    16'sd256,    1'b1, '{8'd0,   8'd255, 8'd255}},
		'{16'sd240,    16'sd256,    16'sd256,    1'b1, '{8'd0,   8'd0,   8'd255}},
		'{16'sd300,    16'sd256,    16'sd256,    1'b1, '{8'd255, 8'd0,   8'd255}},
		'{16'sd360,    16'sd256,    16'sd256,    1'b1, '{8'd255, 8'd0,   8'd0}},
		'{-16'sd1,     16'sd256,    16'sd256,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{-16'sd360,   16'sd256,    16'sd256,    1'b1, '{8'd255, 8'd0,   8'd0}},
		'{-16'sd32768, 16'sd256,    16'sd256,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd32767,  16'sd256,    16'sd256,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd90,     -16'sd1,     16'sd256,    1'b1, '{8'd255, 8'd255, 8'd255}},
		'{16'sd90,     -16'sd32768, 16'sd256,    1'b1, '{8'd255, 8'd255, 8'd255}},
		'{16'sd0,      16'sd32767,  16'sd256,    1'b1, '{8'd255, 8'd0,   8'd0}},
		'{16'sd200,    16'sd0,      16'sd32767,  1'b1, '{8'd255, 8'd255, 8'd255}},
		'{16'sd200,    16'sd128,    -16'sd1,     1'b1, '{8'd0,   8'd0,   8'd0}},
		'{16'sd200,    16'sd128,    -16'sd32768, 1'b1, '{8'd0,   8'd0,   8'd0}},
		'{16'sd359,    16'sd128,    16'sd200,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd30,     16'sd128,    16'sd128,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd150,    16'sd257,    16'sd255,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd270,    16'sd64,     16'sd192,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd45,     16'sd200,    16'sd256,    1'b0, '{8'd0,   8'd0,   8'd0}},
		'{16'sd330,    16'sd100,    16'sd100,    1'b0, '{8'd0,   8'd0,   8'd0}}
	};

	hsv_to_rgb_converter_top #(
		.FRAC_BITS(FRAC_BITS_DEF)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue_degrees(hue_degrees),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned clamp_unit(logic signed [15:0] x);
		if (x < 0) begin
			return 0;
		end else if (x > UNIT) begin
			return UNIT;
		end
		return 64'(x);
	endfunction

	// floor(255 * v * n / (60 * UNIT^2)), exact
	function automatic logic [7:0] scale_channel(longint unsigned v, longint unsigned n);
		longint unsigned den;
		den = 64'(SECTOR_DEG) * 64'(UNIT) * 64'(UNIT);
		return 8'((64'(CHAN_MAX) * v * n) / den);
	endfunction

	function automatic rgb_t hsv_to_rgb_predict(logic signed [15:0] h_in,
			logic signed [15:0] s_in, logic signed [15:0] v_in);
		int              h;
		longint unsigned s, v, r, full;
		logic [7:0]      cv, cp, cq, ct;
		sector_t         sec;
		rgb_t            o;
		h = int'(h_in) % HUE_FULL;
		if (h < 0) begin
			h += HUE_FULL;
		end
		s    = clamp_unit(s_in);
		v    = clamp_unit(v_in);
		sec  = sector_t'(h / SECTOR_DEG);
		r    = 64'(h % SECTOR_DEG);
		full = 64'(SECTOR_DEG) * 64'(UNIT);
		cv   = scale_channel(v, full);
		cp   = scale_channel(v, 64'(SECTOR_DEG) * (64'(UNIT) - s));
		cq   = scale_channel(v, full - s * r);
		ct   = scale_channel(v, full - s * (64'(SECTOR_DEG) - r));
		case (sec)
			SEC_YG: o = '{cq, cv, cp};
			SEC_GC: o = '{cp, cv, ct};
			SEC_CB: o = '{cp, cq, cv};
			SEC_BM: o = '{ct, cp, cv};
			SEC_MR: o = '{cv, cp, cq};
			default: o = '{cv, ct, cp};
		endcase
		return o;
	endfunction

	// mostly hue in -720..719 and unit fields in range or near the clamp edges, sometimes the full 16-bit span
	function automatic logic signed [15:0] rand_hue();
		if ($urandom_range(0, 3) == 0) begin
			return 16'($urandom);
		end
		return 16'(int'($urandom_range(0, 1439)) - 720);
	endfunction

	function automatic logic signed [15:0] rand_unit();
		if ($urandom_range(0, 3) == 0) begin
			return 16'($urandom);
		end else if ($urandom_range(0, 4) == 0) begin
			return 16'(int'($urandom_range(0, 8)) - 4 + ($urandom_range(0, 1) ? UNIT : 0));
		end
		return 16'($urandom_range(0, UNIT));
	endfunction

	task automatic log_mismatch(input string what, input rgb_t want, input rgb_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
				$realtime, what, want.r, want.g, want.b, got.r, got.g, got.b);
		end
	endtask

	// present one color and hold it until the transfer happens
	task automatic offer_color(input logic signed [15:0] h, input logic signed [15:0] s,
			input logic signed [15:0] v, input rgb_t want);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				hsv_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		hue_degrees <= h;
		saturation  <= s;
		brightness  <= v;
		hsv_valid   <= 1'b1;
		pending_rgb = want;
		do @(posedge clk); while (!(hsv_valid && !hsv_stall));
		items_sent++;
	endtask

	// output check first, then record the input transfer of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rgb_valid && !rgb_stall) begin
				results_seen++;
				if (rgb_expect_q.size() == 0) begin
					log_mismatch("unexpected result", '0, '{red, green, blue});
				end else begin
					popped_rgb = rgb_expect_q.pop_front();
					if (red !== popped_rgb.r || green !== popped_rgb.g
							|| blue !== popped_rgb.b) begin
						log_mismatch("rgb mismatch", popped_rgb, '{red, green, blue});
					end
				end
			end
			if (hsv_valid && !hsv_stall) begin
				rgb_expect_q = {rgb_expect_q, pending_rgb};
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, rgb_expect_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: one long hold-off early on, then segments of varying stall density
	initial begin
		int seg_len;
		int mode;
		wait (arst_n === 1'b1);
		repeat (300) begin
			@(negedge clk);
			rgb_stall <= ($urandom_range(0, 3) == 0);
		end
		@(negedge clk);
		rgb_stall <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_done = 1;
		forever begin
			seg_len = $urandom_range(10, 60);
			mode    = $urandom_range(0, 3);
			repeat (seg_len) begin
				@(negedge clk);
				case (mode)
					0: rgb_stall <= 1'b0;
					1: rgb_stall <= ($urandom_range(0, 3) == 0);
					2: rgb_stall <= ($urandom_range(0, 9) < 6);
					default: rgb_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		logic signed [15:0] h, s, v;
		rgb_t               want;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (color_tab[i]) begin
			want = color_tab[i].typed ? color_tab[i].rgb
				: hsv_to_rgb_predict(color_tab[i].hue, color_tab[i].sat, color_tab[i].val);
			offer_color(color_tab[i].hue, color_tab[i].sat, color_tab[i].val, want);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// let the pipeline drain completely before continuing
				@(negedge clk);
				hsv_valid <= 1'b0;
				while (rgb_expect_q.size() != 0) @(posedge clk);
				burst_left = 0;
			end
			h = rand_hue();
			s = rand_unit();
			v = rand_unit();
			offer_color(h, s, v, hsv_to_rgb_predict(h, s, v));
		end

		@(negedge clk);
		hsv_valid <= 1'b0;
		while (rgb_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatch_count += rgb_expect_q.size();

		$display("Sent %0d colors (%0d directed corners), checked %0d RGB results",
			items_sent, N_DIRECTED, results_seen);
		$display("Output hold-off of %0d cycles done: %0d, mid-run drain done, %0d cycles",
			HOLD_CYCLES, hold_done, cycle_count);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/hsv_pkg.sv
hdl/hsv_hue.sv
hdl/hsv_chan.sv
hdl/hsv_to_rgb_converter_top.sv
dv/hsv_to_rgb_converter_top_tb.sv
